// File: rtl/lse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// shared constants and types of the legendre series evaluator
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam int MAX_TERMS = 16;
	localparam int FRAC_BITS = 30;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SUM   = 2'd1;
	localparam logic [1:0] OP_TERMS = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] CFG_DOMAIN_LOW  = 2'd0;
	localparam logic [1:0] CFG_DOMAIN_HIGH = 2'd1;
	localparam logic [1:0] CFG_TERM_COUNT  = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  coef_index;
		logic [31:0] coef_value;
		logic        undef;
		logic        num_neg;
		logic [32:0] num_mag;
		logic [32:0] den;
		logic [4:0]  cnt;
	} lse_req_t;

endpackage
`default_nettype wire

// File: rtl/legendre_series_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// legendre_series_evaluator
// fixed-point legendre series and term evaluation
// ----------------------------------------------------------------------------
// requests enter on in_valid/in_ready: op 0 stores a coefficient, op 1 gives
// the weighted series sum at x_value, op 2 gives each term value in turn with
// last on the final one; op 3 is dropped
// configuration (domain ends, term count) is written on cfg_valid/cfg_ready;
// the user must write it only while idle (unchecked); cfg_ready stays high
// the front sets up the domain mapping of x and a queue holds up to two
// requests; the back runs one request at a time
// a coefficient write is stored when the back pops it; an evaluation's length
// is set by the bit-serial domain division and, per term, by the two-pass
// multiplier and the 8-bit-per-cycle division by the term number
// an x outside the domain gives zero values with undefined set
// reset clears the coefficients to zero and the domain to [-1, 1], one term
// when out_ready is low the result register holds; the back waits for it and
// the front keeps taking requests until its queue fills
// ----------------------------------------------------------------------------
module legendre_series_evaluator import lse_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [3:0]  coef_index,
	input  wire logic [31:0] coef_value,
	input  wire logic [31:0] x_value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [47:0]      value,
	output logic [3:0]       term_index,
	output logic             undefined,
	output logic             last
);

	lse_req_t push_req;
	lse_req_t q_req;
	logic     push;
	logic     full;
	logic     pop;
	logic     q_valid;

	lse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.x_value    (x_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.full       (full),
		.push       (push),
		.req        (push_req)
	);

	lse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.full     (full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_req    (q_req)
	);

	lse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_req      (q_req),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.term_index (term_index),
		.undefined  (undefined),
		.last       (last)
	);

endmodule
`default_nettype wire

// File: rtl/lse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_front
// accepts requests, holds configuration, classifies and maps the domain
// ----------------------------------------------------------------------------
module lse_front import lse_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [3:0]  coef_index,
	input  wire logic [31:0] coef_value,
	input  wire logic [31:0] x_value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        full,
	output logic             push,
	output lse_req_t         req
);

	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;
	logic [4:0]         tc_q;
	logic signed [33:0] num;
	logic [33:0]        num_abs;
	logic [4:0]         cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= 32'shFFFF0000;
			hi_q <= 32'sh00010000;
			tc_q <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DOMAIN_LOW:  lo_q <= cfg_data;
				CFG_DOMAIN_HIGH: hi_q <= cfg_data;
				CFG_TERM_COUNT:  tc_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		num = $signed({x_value[31], x_value, 1'b0}) - $signed({{2{lo_q[31]}}, lo_q})
			- $signed({{2{hi_q[31]}}, hi_q});
		num_abs = num[33] ? (34'd0 - num) : num;
		if (tc_q == 5'd0)
			cnt = 5'd1;
		else if (tc_q > 5'(MAX_TERMS))
			cnt = 5'(MAX_TERMS);
		else
			cnt = tc_q;
	end

	assign in_ready = !full;
	assign push     = in_valid && !full && (op != OP_NONE);

	always_comb begin
		req.op         = op;
		req.coef_index = coef_index;
		req.coef_value = coef_value;
		req.undef      = (hi_q <= lo_q) || ($signed(x_value) < lo_q) || ($signed(x_value) > hi_q);
		req.num_neg    = num[33];
		req.num_mag    = num_abs[32:0];
		req.den        = 33'({hi_q[31], hi_q} - {lo_q[31], lo_q});
		req.cnt        = cnt;
	end

endmodule
`default_nettype wire

// File: rtl/lse_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module lse_queue import lse_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire lse_req_t push_req,
	output logic          full,
	input  wire logic     pop,
	output logic          q_valid,
	output lse_req_t      q_req
);

	lse_req_t   ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/lse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_back
// sequencer: domain division, term recurrence, weighted sum, result register
// ----------------------------------------------------------------------------
module lse_back import lse_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire lse_req_t    q_req,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [47:0]      value,
	output logic [3:0]       term_index,
	output logic             undefined,
	output logic             last
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DIV    = 4'd1;
	localparam logic [3:0] ST_DIVEND = 4'd2;
	localparam logic [3:0] ST_TERM   = 4'd3;
	localparam logic [3:0] ST_SCALE  = 4'd4;
	localparam logic [3:0] ST_MUL0   = 4'd5;
	localparam logic [3:0] ST_MUL1   = 4'd6;
	localparam logic [3:0] ST_RND    = 4'd7;
	localparam logic [3:0] ST_SUB    = 4'd8;
	localparam logic [3:0] ST_DVN    = 4'd9;
	localparam logic [3:0] ST_DVEND  = 4'd10;
	localparam logic [3:0] ST_USE    = 4'd11;
	localparam logic [3:0] ST_NEXT   = 4'd12;
	localparam logic [3:0] ST_FIN    = 4'd13;
	localparam logic [3:0] ST_UNDEF  = 4'd14;

	logic [3:0]         state_q;
	logic               sum_mode_q;
	logic [4:0]         cnt_q;
	logic [4:0]         i_q;
	logic [4:0]         step_q;
	logic [33:0]        r_q;
	logic [32:0]        den_q;
	logic [31:0]        dq_q;
	logic               neg_q;
	logic [31:0]        t_q;
	logic [35:0]        p1_q;
	logic [35:0]        p2_q;
	logic [35:0]        pc_q;
	logic [34:0]        m_q;
	logic [35:0]        mb_q;
	logic               msign_q;
	logic               macc_q;
	logic [71:0]        acc_q;
	logic [37:0]        a_q;
	logic [39:0]        b_q;
	logic [39:0]        u_q;
	logic [39:0]        nq_q;
	logic [3:0]         rem_q;
	logic               vneg_q;
	logic [47:0]        sum_q;

	logic [31:0]        mem_q [MAX_TERMS];
	logic [MAX_TERMS-1:0] vld_q;
	logic [31:0]        coef_q;
	logic               coef_vld_q;

	// combinational helpers
	logic               out_free;
	logic               load;
	logic [47:0]        ld_value;
	logic [3:0]         ld_index;
	logic               ld_undef;
	logic               ld_last;
	logic               mem_we;
	logic [33:0]        r_shift;
	logic [31:0]        q_rnd;
	logic [31:0]        t_mag;
	logic [35:0]        p1_mag;
	logic [35:0]        pc_mag;
	logic [31:0]        coef;
	logic [32:0]        coef_mag;
	logic [5:0]         k_odd;
	logic [3:0]         im1;
	logic signed [40:0] bprod;
	logic [71:0]        rnd;
	logic [47:0]        val48;
	logic [40:0]        v;
	logic [40:0]        v_abs;
	logic [4:0]         rem5;
	logic [3:0]         rem_n;
	logic [7:0]         qbits;
	logic [39:0]        nq_neg;
	logic               is_last;

	assign out_free = !out_valid || out_ready;
	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign mem_we   = pop && (q_req.op == OP_WRITE);
	assign coef     = coef_vld_q ? coef_q : 32'd0;
	assign is_last  = ((i_q + 5'd1) == cnt_q);

	always_comb begin
		r_shift  = {r_q[32:0], 1'b0};
		q_rnd    = dq_q + {31'd0, (r_shift >= {1'b0, den_q})};
		t_mag    = t_q[31] ? (32'd0 - t_q) : t_q;
		p1_mag   = p1_q[35] ? (36'd0 - p1_q) : p1_q;
		pc_mag   = pc_q[35] ? (36'd0 - pc_q) : pc_q;
		coef_mag = coef[31] ? (33'd0 - {coef[31], coef}) : {1'b0, coef};
		k_odd    = {i_q, 1'b0} - 6'd1;
		im1      = 4'(i_q - 5'd1);
		bprod    = $signed({1'b0, im1}) * $signed({{5{p2_q[35]}}, p2_q});
		rnd      = acc_q + (72'd1 << (FRAC_BITS - 1));
		val48    = msign_q ? (48'd0 - {6'd0, rnd[71:30]}) : {6'd0, rnd[71:30]};
		v        = {{3{a_q[37]}}, a_q} - {b_q[39], b_q};
		v_abs    = v[40] ? (41'd0 - v) : v;
		nq_neg   = 40'd0 - nq_q;
		rem_n    = rem_q;
		qbits    = 8'd0;
		for (int k = 0; k < 8; k++) begin
			rem5 = {rem_n, u_q[39 - k]};
			if (rem5 >= i_q) begin
				rem5     = rem5 - i_q;
				qbits[7 - k] = 1'b1;
			end
			rem_n = rem5[3:0];
		end
	end

	// result register load
	always_comb begin
		load     = 1'b0;
		ld_value = 48'd0;
		ld_index = 4'd0;
		ld_undef = 1'b0;
		ld_last  = 1'b0;
		case (state_q)
			ST_USE: begin
				if (!sum_mode_q && out_free) begin
					load     = 1'b1;
					ld_value = {{12{pc_q[35]}}, pc_q};
					ld_index = i_q[3:0];
					ld_last  = is_last;
				end
			end
			ST_FIN: begin
				load     = out_free;
				ld_value = sum_q;
				ld_last  = 1'b1;
			end
			ST_UNDEF: begin
				load     = out_free;
				ld_index = sum_mode_q ? 4'd0 : i_q[3:0];
				ld_undef = 1'b1;
				ld_last  = sum_mode_q || is_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value      <= ld_value;
			term_index <= ld_index;
			undefined  <= ld_undef;
			last       <= ld_last;
		end
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[q_req.coef_index] <= q_req.coef_value;
		coef_q <= mem_q[i_q[3:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			coef_vld_q <= 1'b0;
		end else begin
			if (mem_we)
				vld_q[q_req.coef_index] <= 1'b1;
			coef_vld_q <= vld_q[i_q[3:0]];
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sum_mode_q <= 1'b0;
			cnt_q      <= 5'd1;
			i_q        <= 5'd0;
			step_q     <= 5'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && (q_req.op != OP_WRITE)) begin
						sum_mode_q <= (q_req.op == OP_SUM);
						cnt_q      <= q_req.cnt;
						i_q        <= 5'd0;
						step_q     <= 5'd0;
						state_q    <= q_req.undef ? ST_UNDEF : ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(FRAC_BITS - 1))
						state_q <= ST_DIVEND;
				end
				ST_DIVEND: state_q <= ST_TERM;
				ST_TERM:   state_q <= (i_q < 5'd2) ? ST_USE : ST_SCALE;
				ST_SCALE:  state_q <= ST_MUL0;
				ST_MUL0:   state_q <= ST_MUL1;
				ST_MUL1:   state_q <= ST_RND;
				ST_RND:    state_q <= macc_q ? ST_NEXT : ST_SUB;
				ST_SUB: begin
					step_q  <= 5'd0;
					state_q <= ST_DVN;
				end
				ST_DVN: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd4)
						state_q <= ST_DVEND;
				end
				ST_DVEND: state_q <= ST_USE;
				ST_USE: begin
					if (sum_mode_q)
						state_q <= ST_MUL0;
					else if (out_free)
						state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					i_q <= i_q + 5'd1;
					if (is_last)
						state_q <= sum_mode_q ? ST_FIN : ST_IDLE;
					else
						state_q <= ST_TERM;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				ST_UNDEF: begin
					if (out_free) begin
						i_q <= i_q + 5'd1;
						if (sum_mode_q || is_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				den_q  <= q_req.den;
				neg_q  <= q_req.num_neg;
				sum_q  <= 48'd0;
				macc_q <= 1'b0;
				if ({1'b0, q_req.num_mag} >= {1'b0, q_req.den}) begin
					r_q  <= {1'b0, q_req.num_mag - q_req.den};
					dq_q <= 32'd1;
				end else begin
					r_q  <= {1'b0, q_req.num_mag};
					dq_q <= 32'd0;
				end
			end
			ST_DIV: begin
				if (r_shift >= {1'b0, den_q}) begin
					r_q  <= r_shift - {1'b0, den_q};
					dq_q <= {dq_q[30:0], 1'b1};
				end else begin
					r_q  <= r_shift;
					dq_q <= {dq_q[30:0], 1'b0};
				end
			end
			ST_DIVEND: t_q <= neg_q ? (32'd0 - q_rnd) : q_rnd;
			ST_TERM: begin
				if (i_q == 5'd0)
					pc_q <= 36'd1 << FRAC_BITS;
				else if (i_q == 5'd1)
					pc_q <= {{4{t_q[31]}}, t_q};
			end
			ST_SCALE: begin
				m_q     <= 35'(t_mag[30:0] * k_odd);
				mb_q    <= p1_mag;
				msign_q <= t_q[31] ^ p1_q[35];
				macc_q  <= 1'b0;
				b_q     <= bprod[39:0];
			end
			ST_MUL0: acc_q <= 72'(m_q * mb_q[17:0]);
			ST_MUL1: acc_q <= acc_q + (72'(m_q * mb_q[35:18]) << 18);
			ST_RND: begin
				if (macc_q)
					sum_q <= sum_q + val48;
				else
					a_q <= val48[37:0];
			end
			ST_SUB: begin
				u_q    <= v_abs[39:0] + {36'd0, i_q[4:1]};
				vneg_q <= v[40];
				rem_q  <= 4'd0;
				nq_q   <= 40'd0;
			end
			ST_DVN: begin
				u_q   <= {u_q[31:0], 8'd0};
				nq_q  <= {nq_q[31:0], qbits};
				rem_q <= rem_n;
			end
			ST_DVEND: pc_q <= vneg_q ? nq_neg[35:0] : nq_q[35:0];
			ST_USE: begin
				if (sum_mode_q) begin
					m_q     <= {2'd0, coef_mag};
					mb_q    <= pc_mag;
					msign_q <= coef[31] ^ pc_q[35];
					macc_q  <= 1'b1;
				end
			end
			ST_NEXT: begin
				p2_q <= p1_q;
				p1_q <= pc_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: dv/legendre_series_evaluator_tb.sv
// ----------------------------------------------------------------------------
// legendre_series_evaluator_tb
// drives coefficient writes, sum and per-term requests through several domain
// and term-count settings, predicts every result in fixed point and checks
// each one in order while both sides of the block idle and stall at random
// ----------------------------------------------------------------------------
module legendre_series_evaluator_tb;
	import lse_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic [47:0] value;
		logic [3:0]  term_index;
		logic        undef;
		logic        last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [3:0]  coef_index;
	logic [31:0] coef_value;
	logic [31:0] x_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        out_valid;
	logic        out_ready;
	logic [47:0] value;
	logic [3:0]  term_index;
	logic        undefined;
	logic        last;

	result_t     expected_results[$];
	longint      dom_lo;
	longint      dom_hi;
	logic [4:0]  term_cnt;
	longint      coef_mem[MAX_TERMS];
	longint      poly_val[MAX_TERMS];
	int          error_count;
	int          cycle_count;
	int          hold_left;
	int          stall_pct;
	int          burst_left;
	int          gap_max;

	legendre_series_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .coef_index(coef_index), .coef_value(coef_value), .x_value(x_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .term_index(term_index), .undefined(undefined), .last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// fixed-point arithmetic of the series

	function automatic longint mul_round(input longint a, input longint b);
		logic [127:0] prod;
		logic [63:0]  ua;
		logic [63:0]  ub;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		prod = {64'd0, ua} * {64'd0, ub};
		prod = (prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (prod > (128'd1 << 62))
			prod = 128'd1 << 62;
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic longint div_round(input longint v, input longint n);
		longint u;
		u = (v < 0) ? -v : v;
		u = (u + n / 2) / n;
		return (v < 0) ? -u : u;
	endfunction

	// fills poly_val, returns 1 for an undefined point
	function automatic bit legendre_terms(input logic [31:0] xr, input int cnt);
		longint       x;
		longint       den;
		longint       num;
		longint       t;
		logic [95:0]  mag;
		logic [95:0]  dn;
		logic [95:0]  q;
		logic [95:0]  r;
		x = longint'($signed(xr));
		for (int i = 0; i < MAX_TERMS; i++)
			poly_val[i] = 0;
		if (dom_hi <= dom_lo || x < dom_lo || x > dom_hi)
			return 1'b1;
		den = dom_hi - dom_lo;
		num = 2 * x - dom_lo - dom_hi;
		mag = (num < 0) ? -num : num;
		mag = mag << FRAC_BITS;
		dn = den;
		q = mag / dn;
		r = mag % dn;
		if (2 * r >= dn)
			q = q + 1;
		t = (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
		poly_val[0] = longint'(1) << FRAC_BITS;
		if (cnt > 1)
			poly_val[1] = t;
		for (int i = 2; i < cnt; i++)
			poly_val[i] = div_round(mul_round(longint'(2 * i - 1) * t, poly_val[i - 1])
				- longint'(i - 1) * poly_val[i - 2], i);
		return 1'b0;
	endfunction

	task automatic predict_request(input logic [1:0] o, input logic [3:0] idx,
		input logic [31:0] cv, input logic [31:0] xr);
		int      cnt;
		bit      undef;
		longint  sum;
		result_t res;
		if (o == OP_WRITE) begin
			coef_mem[idx] = longint'($signed(cv));
			return;
		end
		if (o == OP_NONE)
			return;
		cnt = term_cnt;
		if (cnt < 1)
			cnt = 1;
		if (cnt > MAX_TERMS)
			cnt = MAX_TERMS;
		undef = legendre_terms(xr, cnt);
		if (o == OP_SUM) begin
			sum = 0;
			if (!undef) begin
				for (int i = 0; i < cnt; i++)
					sum += mul_round(coef_mem[i], poly_val[i]);
				if (sum > 64'sd140737488355327)
					sum = 64'sd140737488355327;
				if (sum < -64'sd140737488355328)
					sum = -64'sd140737488355328;
			end
			res.value = sum[47:0];
			res.term_index = 4'd0;
			res.undef = undef;
			res.last = 1'b1;
			expected_results.push_back(res);
		end else begin
			for (int i = 0; i < cnt; i++) begin
				res.value = poly_val[i][47:0];
				res.term_index = i[3:0];
				res.undef = undef;
				res.last = (i == cnt - 1);
				expected_results.push_back(res);
			end
		end
	endtask

	// request side

	task automatic send_request(input logic [1:0] o, input logic [3:0] idx,
		input logic [31:0] cv, input logic [31:0] xr);
		predict_request(o, idx, cv, xr);
		@(negedge clk);
		op <= o;
		coef_index <= idx;
		coef_value <= cv;
		x_value <= xr;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if (gap_max > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, gap_max)) @(negedge clk);
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DOMAIN_LOW:  dom_lo = longint'($signed(d));
			CFG_DOMAIN_HIGH: dom_hi = longint'($signed(d));
			CFG_TERM_COUNT:  term_cnt = d[4:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] lo, input logic [31:0] hi,
		input logic [31:0] tc);
		settle();
		write_register(CFG_DOMAIN_LOW, lo);
		write_register(CFG_DOMAIN_HIGH, hi);
		write_register(CFG_TERM_COUNT, tc);
	endtask

	function automatic logic [31:0] pick_x();
		longint span;
		if (dom_hi <= dom_lo || $urandom_range(0, 4) == 0)
			return $urandom;
		case ($urandom_range(0, 9))
			0: return dom_lo[31:0];
			1: return dom_hi[31:0];
			default: begin
				span = dom_hi - dom_lo + 1;
				return 32'(dom_lo + longint'({$urandom, $urandom} % 64'(span)));
			end
		endcase
	endfunction

	task automatic send_random(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 15)
				send_request(OP_WRITE, 4'($urandom), $urandom, $urandom);
			else if (k < 20)
				send_request(OP_NONE, 4'($urandom), $urandom, $urandom);
			else if (k < 60)
				send_request(OP_SUM, 4'($urandom), $urandom, pick_x());
			else
				send_request(OP_TERMS, 4'($urandom), $urandom, pick_x());
		end
	endtask

	// tests

	task automatic test_directed();
		configure(32'hFFFF0000, 32'h00010000, 32'd16);
		send_request(OP_WRITE, 4'd0, 32'h7FFFFFFF, 32'h0);
		send_request(OP_WRITE, 4'd15, 32'h80000000, 32'hFFFFFFFF);
		send_request(OP_WRITE, 4'd7, 32'h00010000, 32'h0);
		send_request(OP_SUM, 4'd0, 32'h0, 32'hFFFF0000);
		send_request(OP_SUM, 4'd0, 32'h0, 32'h00010000);
		send_request(OP_SUM, 4'd0, 32'h0, 32'h00000000);
		send_request(OP_TERMS, 4'd0, 32'h0, 32'h00008000);
		send_request(OP_SUM, 4'd0, 32'h0, 32'h00010001);
		send_request(OP_TERMS, 4'd0, 32'h0, 32'h80000000);
		send_request(OP_TERMS, 4'd0, 32'h0, 32'h7FFFFFFF);
		send_request(OP_NONE, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(OP_SUM, 4'd0, 32'h0, 32'hFFFF8000);
		configure(32'h80000000, 32'h7FFFFFFF, 32'd3);
		send_request(OP_SUM, 4'd0, 32'h0, 32'h80000000);
		send_request(OP_TERMS, 4'd0, 32'h0, 32'h7FFFFFFF);
		send_request(OP_SUM, 4'd0, 32'h0, 32'h0);
	endtask

	task automatic test_empty_domain();
		configure(32'h00010000, 32'h00010000, 32'd2);
		send_request(OP_SUM, 4'd0, 32'h0, 32'h00010000);
		send_request(OP_TERMS, 4'd0, 32'h0, 32'h00010000);
		configure(32'h00020000, 32'hFFFE0000, 32'd4);
		send_random(12);
	endtask

	task automatic test_term_count_limits();
		configure(32'hFFFF0000, 32'h00010000, 32'd0);
		send_random(15);
		configure(32'hFFFC8000, 32'h00024000, 32'd31);
		send_random(12);
		configure(32'h00000000, 32'h00018000, 32'd17);
		send_random(8);
	endtask

	task automatic test_random_settings();
		configure(32'hFFFF0000, 32'h00010000, 32'd4);
		send_random(40);
		stall_pct = 0;
		gap_max = 0;
		configure(32'h80000000, 32'h7FFFFFFF, 32'd16);
		send_random(15);
		stall_pct = 40;
		gap_max = 6;
		configure(32'h00000000, 32'h00000001, 32'd1);
		send_random(20);
		for (int i = 0; i < 3; i++) begin
			configure(32'(-$urandom_range(1, 32'h00400000)),
				32'($urandom_range(1, 32'h00400000)), $urandom_range(1, 16));
			stall_pct = $urandom_range(0, 70);
			send_random(20);
		end
	endtask

	task automatic test_backpressure();
		stall_pct = 20;
		configure(32'hFFFF0000, 32'h00010000, 32'd8);
		hold_left = 800;
		gap_max = 0;
		for (int i = 0; i < 10; i++)
			send_request((i % 2) ? OP_SUM : OP_TERMS, 4'd0, 32'h0, pick_x());
		gap_max = 6;
		// stop offering until everything has drained, then go again
		settle();
		send_random(15);
	endtask

	// result side

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result value=%h term_index=%0d", $time, value,
					term_index);
				error_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (value !== exp_res.value) begin
					$display("%0t: value expected %h actual %h", $time, exp_res.value, value);
					error_count++;
				end
				if (term_index !== exp_res.term_index) begin
					$display("%0t: term_index expected %0d actual %0d", $time,
						exp_res.term_index, term_index);
					error_count++;
				end
				if (undefined !== exp_res.undef) begin
					$display("%0t: undefined expected %b actual %b", $time, exp_res.undef,
						undefined);
					error_count++;
				end
				if (last !== exp_res.last) begin
					$display("%0t: last expected %b actual %b", $time, exp_res.last, last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("legendre_series_evaluator_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_NONE;
		coef_index = '0;
		coef_value = '0;
		x_value = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DOMAIN_LOW;
		cfg_data = '0;
		out_ready = 1'b0;
		error_count = 0;
		cycle_count = 0;
		hold_left = 0;
		stall_pct = 30;
		burst_left = 0;
		gap_max = 6;
		dom_lo = -65536;
		dom_hi = 65536;
		term_cnt = 5'd1;
		for (int i = 0; i < MAX_TERMS; i++)
			coef_mem[i] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_empty_domain();
		test_term_count_limits();
		test_random_settings();
		test_backpressure();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("legendre_series_evaluator_tb: PASS");
		else
			$display("legendre_series_evaluator_tb: FAIL");
		$finish;
	end

endmodule

// File: legendre_series_evaluator.f
rtl/lse_pkg.sv
rtl/lse_front.sv
rtl/lse_queue.sv
rtl/lse_back.sv
rtl/legendre_series_evaluator.sv
dv/legendre_series_evaluator_tb.sv
